### rtl/pno_pkg.sv
// Shared types, constants and the gradient function for the octave noise unit.
`timescale 1ns / 1ps
package pno_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_OCT   = 8;
  localparam int IDX_W     = 8;
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 19;
  localparam int FR_W      = 18;   // corner offset, signed
  localparam int G_W       = 20;   // gradient and lerp values
  localparam int D_W       = 21;   // lerp difference, multiplier operand
  localparam int SUM_W     = 22;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // steps within one octave
  localparam logic [4:0] STEP_READ_LAST = 5'd13;
  localparam logic [4:0] STEP_FADE_END  = 5'd12;
  localparam logic [4:0] STEP_LERP_LAST = 5'd29;
  localparam logic [4:0] STEP_ACC       = 5'd30;

  localparam logic [1:0] FOP_T2   = 2'd0;
  localparam logic [1:0] FOP_POLY = 2'd1;
  localparam logic [1:0] FOP_T3   = 2'd2;
  localparam logic [1:0] FOP_FADE = 2'd3;

  localparam logic [1:0] W_U = 2'd0;
  localparam logic [1:0] W_V = 2'd1;
  localparam logic [1:0] W_W = 2'd2;

  localparam logic [3:0] SLOT_A      = 4'd0;
  localparam logic [3:0] SLOT_B      = 4'd1;
  localparam logic [3:0] SLOT_AA     = 4'd2;
  localparam logic [3:0] SLOT_AB     = 4'd3;
  localparam logic [3:0] SLOT_BA     = 4'd4;
  localparam logic [3:0] SLOT_BB     = 4'd5;
  localparam logic [3:0] SLOT_CORNER = 4'd6;

  typedef struct packed {
    logic       wr_en;
    logic       start;
    logic       rd_en;
    logic [3:0] rd_slot;
    logic       fade_en;
    logic [1:0] fop;
    logic [1:0] csel;
    logic       ldiff;
    logic       lmul;
    logic [1:0] wsel;
    logic       accum;
    logic [2:0] oct_idx;
    logic       load_out;
  } cmd_t;

  function automatic logic signed [G_W-1:0] grad(input logic [3:0] h,
                                                  input logic signed [FR_W-1:0] x,
                                                  input logic signed [FR_W-1:0] y,
                                                  input logic signed [FR_W-1:0] z);
    logic signed [G_W-1:0] gu;
    logic signed [G_W-1:0] gv;
    gu = (h < 4'd8) ? G_W'(x) : G_W'(y);
    if (h < 4'd4) begin
      gv = G_W'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = G_W'(x);
    end else begin
      gv = G_W'(z);
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

endpackage

### rtl/pno_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pno_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/pno_datapath.sv
// Datapath: permutation table, hashing, fade, lerp multiplier and octave sum.
`timescale 1ns / 1ps
module pno_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pno_pkg::cmd_t       cmd,
  input  logic [7:0]          table_index,
  input  logic [7:0]          table_value,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic                unit_range,
  output logic signed [18:0]  noise_value
);
  import pno_pkg::*;

  logic [COORD_W-1:0] ux, uy, uz;
  logic               unit_q;
  logic [IDX_W-1:0]   a_idx, b_idx, aa, ab, ba, bb;
  logic signed [G_W-1:0] q [8];
  logic [3:0]         n;
  logic [15:0]        t2, t3;
  logic [D_W-1:0]     poly;
  logic signed [FR_W-1:0] fade_u, fade_v, fade_w;
  logic signed [D_W-1:0] d;
  logic signed [G_W-1:0] base;
  logic signed [SUM_W-1:0] sum;
  logic               rd_en_q;
  logic [3:0]         rd_slot_q;

  logic [IDX_W-1:0]   cx, cy, cz, rd_addr, ram_addr, rdata, cbase;
  logic [3:0]         kk, kq;
  logic [2:0]         k, kc;
  logic [15:0]        t;
  logic signed [FR_W-1:0] wt, gx, gy, gz;
  logic signed [D_W-1:0]  ma, mb;
  logic signed [41:0]     prod, prod_sh;
  logic [22:0]            pc;
  logic signed [G_W-1:0]  lres, nsh;
  logic signed [SUM_W-1:0] fin;

  assign cx = ux[FRAC_BITS +: IDX_W];
  assign cy = uy[FRAC_BITS +: IDX_W];
  assign cz = uz[FRAC_BITS +: IDX_W];
  assign kk = cmd.rd_slot - SLOT_CORNER;
  assign k  = kk[2:0];
  assign kq = rd_slot_q - SLOT_CORNER;
  assign kc = kq[2:0];

  always_comb begin
    unique case (k[1:0])
      2'd0:    cbase = aa;
      2'd1:    cbase = ba;
      2'd2:    cbase = ab;
      default: cbase = bb;
    endcase
    unique case (cmd.rd_slot)
      SLOT_A:  rd_addr = cx;
      SLOT_B:  rd_addr = cx + 8'd1;
      SLOT_AA: rd_addr = a_idx;
      SLOT_AB: rd_addr = a_idx + 8'd1;
      SLOT_BA: rd_addr = b_idx;
      SLOT_BB: rd_addr = b_idx + 8'd1;
      default: rd_addr = cbase + {7'd0, k[2]};
    endcase
  end

  assign ram_addr = cmd.wr_en ? table_index : rd_addr;

  pno_ram #(.WIDTH(IDX_W), .DEPTH(256)) u_perm (
    .clk  (clk),
    .we   (cmd.wr_en),
    .addr (ram_addr),
    .wdata(table_value),
    .rdata(rdata)
  );

  // corner offsets: fraction, or fraction minus one
  assign gx = kc[0] ? $signed({2'b11, ux[15:0]}) : $signed({2'b00, ux[15:0]});
  assign gy = kc[1] ? $signed({2'b11, uy[15:0]}) : $signed({2'b00, uy[15:0]});
  assign gz = kc[2] ? $signed({2'b11, uz[15:0]}) : $signed({2'b00, uz[15:0]});

  always_comb begin
    case (cmd.csel)
      2'd1:    t = uy[15:0];
      2'd2:    t = uz[15:0];
      default: t = ux[15:0];
    endcase
    case (cmd.wsel)
      W_U:     wt = fade_u;
      W_V:     wt = fade_v;
      default: wt = fade_w;
    endcase
    if (cmd.lmul) begin
      ma = D_W'(wt);
      mb = d;
    end else begin
      case (cmd.fop)
        FOP_T2: begin
          ma = $signed({5'd0, t});
          mb = $signed({5'd0, t});
        end
        FOP_T3: begin
          ma = $signed({5'd0, t2});
          mb = $signed({5'd0, t});
        end
        default: begin
          ma = $signed({5'd0, t3});
          mb = $signed(poly);
        end
      endcase
    end
  end

  assign prod    = ma * mb;
  assign prod_sh = prod >>> FRAC_BITS;
  assign pc      = {7'd0, t2} * 23'd6 + 23'd655360 - {7'd0, t} * 23'd15;
  assign lres    = base + $signed(prod_sh[G_W-1:0]);
  assign nsh     = q[0] >>> cmd.oct_idx;
  assign fin     = unit_q ? (sum >>> 1) + SUM_W'(32768) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en_q <= 1'b0;
    end else begin
      rd_en_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_q <= cmd.rd_slot;
    if (cmd.start) begin
      ux     <= coord_x;
      uy     <= coord_y;
      uz     <= coord_z;
      unit_q <= unit_range;
      sum    <= '0;
    end
    if (rd_en_q) begin
      unique case (rd_slot_q)
        SLOT_A:  a_idx <= rdata + cy;
        SLOT_B:  b_idx <= rdata + cy;
        SLOT_AA: aa    <= rdata + cz;
        SLOT_AB: ab    <= rdata + cz;
        SLOT_BA: ba    <= rdata + cz;
        SLOT_BB: bb    <= rdata + cz;
        default: begin
          q[kc] <= grad(rdata[3:0], gx, gy, gz);
          if (kc == 3'd7) begin
            n <= 4'd8;
          end
        end
      endcase
    end
    if (cmd.fade_en) begin
      unique case (cmd.fop)
        FOP_T2:   t2 <= prod_sh[15:0];
        FOP_POLY: poly <= pc[D_W-1:0];
        FOP_T3:   t3 <= prod_sh[15:0];
        default: begin
          case (cmd.csel)
            2'd1:    fade_v <= prod_sh[FR_W-1:0];
            2'd2:    fade_w <= prod_sh[FR_W-1:0];
            default: fade_u <= prod_sh[FR_W-1:0];
          endcase
        end
      endcase
    end
    if (cmd.ldiff) begin
      d    <= D_W'(q[1]) - D_W'(q[0]);
      base <= q[0];
      for (int i = 0; i < 6; i++) begin
        q[i] <= q[i+2];
      end
      n <= n - 4'd2;
    end
    if (cmd.lmul) begin
      q[n[2:0]] <= lres;
      n         <= n + 4'd1;
    end
    if (cmd.accum) begin
      sum <= sum + SUM_W'(nsh);
      ux  <= {ux[COORD_W-2:0], 1'b0};
      uy  <= {uy[COORD_W-2:0], 1'b0};
      uz  <= {uz[COORD_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      if (fin > SUM_W'(262143)) begin
        noise_value <= 19'sh3FFFF;
      end else if (fin < -SUM_W'(262144)) begin
        noise_value <= 19'sh40000;
      end else begin
        noise_value <= fin[OUT_W-1:0];
      end
    end
  end
endmodule

### rtl/pno_ctrl.sv
// Controller: handshakes, octave loop and per-octave step sequence.
`timescale 1ns / 1ps
module pno_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [3:0]    octave_count,
  output logic          out_valid,
  input  logic          out_ready,
  output pno_pkg::cmd_t cmd
);
  import pno_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [4:0] step;
  logic [3:0] oct, count, cnt_sat;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_sat  = (octave_count > 4'(MAX_OCT)) ? 4'(MAX_OCT) : octave_count;

  always_comb begin
    cmd         = '0;
    cmd.wr_en   = accept && (kind == KIND_LOAD);
    cmd.start   = accept && (kind == KIND_QUERY);
    cmd.rd_slot = step[3:0];
    cmd.csel    = step[3:2];
    cmd.fop     = step[1:0];
    cmd.oct_idx = oct[2:0];
    if (step[3:1] < 3'd4) begin
      cmd.wsel = W_U;
    end else if (step[3:1] < 3'd6) begin
      cmd.wsel = W_V;
    end else begin
      cmd.wsel = W_W;
    end
    if (state == ST_RUN) begin
      cmd.rd_en   = (step <= STEP_READ_LAST);
      cmd.fade_en = (step < STEP_FADE_END);
      cmd.ldiff   = step[4] && (step <= STEP_LERP_LAST) && !step[0];
      cmd.lmul    = step[4] && (step <= STEP_LERP_LAST) && step[0];
      cmd.accum   = (step == STEP_ACC);
    end
    cmd.load_out = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      oct       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            count <= cnt_sat;
            oct   <= '0;
            step  <= '0;
            state <= (cnt_sat == 4'd0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == STEP_ACC) begin
            step <= '0;
            oct  <= oct + 4'd1;
            if (oct + 4'd1 == count) begin
              state <= ST_DONE;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DONE: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/perlin_noise_octaves_unit.sv
// Top level of the fixed-point 3D Perlin noise unit with octave summation.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | kind, table_index, table_value, coord_x/y/z,
//          |                     | octave_count, unit_range
//  out     | out_valid/out_ready | noise_value
//
// A load word is written to the table when accepted and returns nothing. A query's
// run time is set by the 14 reads per octave on the single-port permutation RAM
// followed by seven lerps on one multiplier.
// Reset clears control only; the table holds garbage until loaded.
// A finished result waits in the output register; the next word is taken
// meanwhile, and a query stalls at its end only while that register is full.
`timescale 1ns / 1ps
module perlin_noise_octaves_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [3:0]         octave_count,
  input  logic               unit_range,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] noise_value
);
  import pno_pkg::*;

  cmd_t cmd;

  pno_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .octave_count(octave_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  pno_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .table_index(table_index),
    .table_value(table_value),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .unit_range (unit_range),
    .noise_value(noise_value)
  );
endmodule

### test/tb_top.sv
// Testbench for the octave Perlin noise unit: table loads and queries against a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import pno_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [3:0]  oct;
    logic        unit;
    int          gap;
    bit          drain;
  } word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = KIND_LOAD;
  logic [7:0]         table_index = '0;
  logic [7:0]         table_value = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic [3:0]         octave_count = '0;
  logic               unit_range = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [18:0] noise_value;

  word_t                pending_q[$];
  logic signed [18:0]   noise_q[$];
  logic [7:0]           perm_mdl[256];
  word_t                cur;
  int                   src_wait = 0;
  int                   snk_wait = 0;
  int                   hold_cnt = 0;
  int                   n_results = 0;
  int                   n_err = 0;

  perlin_noise_octaves_unit i_dut (.*);

  always #1 clk = ~clk;

  function automatic longint fade_w(longint t);
    longint t2, t3, poly;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    poly = 6 * t2 + 10 * 65536 - 15 * t;
    return (t3 * poly) >>> 16;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint corner_dot(int hash, longint x, longint y, longint z);
    int h;
    longint gu, gv;
    h = hash & 15;
    gu = (h < 8) ? x : y;
    gv = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return ((h & 1) ? -gu : gu) + ((h & 2) ? -gv : gv);
  endfunction

  function automatic int pt(int i);
    return int'(perm_mdl[i & 255]);
  endfunction

  function automatic longint lattice_noise(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
    int cx, cy, cz, a, aa, ab, b, ba, bb;
    longint x, y, z, u, v, w, lo, hi, one;
    one = 65536;
    cx = int'(ux[23:16]); cy = int'(uy[23:16]); cz = int'(uz[23:16]);
    x = longint'(ux[15:0]); y = longint'(uy[15:0]); z = longint'(uz[15:0]);
    u = fade_w(x); v = fade_w(y); w = fade_w(z);
    a = pt(cx) + cy;
    aa = pt(a) + cz;
    ab = pt(a + 1) + cz;
    b = pt(cx + 1) + cy;
    ba = pt(b) + cz;
    bb = pt(b + 1) + cz;
    lo = blend(v, blend(u, corner_dot(pt(aa), x, y, z), corner_dot(pt(ba), x - one, y, z)),
               blend(u, corner_dot(pt(ab), x, y - one, z),
                     corner_dot(pt(bb), x - one, y - one, z)));
    hi = blend(v, blend(u, corner_dot(pt(aa + 1), x, y, z - one),
                        corner_dot(pt(ba + 1), x - one, y, z - one)),
               blend(u, corner_dot(pt(ab + 1), x, y - one, z - one),
                     corner_dot(pt(bb + 1), x - one, y - one, z - one)));
    return blend(w, lo, hi);
  endfunction

  function automatic logic signed [18:0] octave_sum(word_t q);
    longint acc;
    int n;
    logic [31:0] ux, uy, uz;
    acc = 0;
    ux = q.x; uy = q.y; uz = q.z;
    n = (q.oct > 4'd8) ? 8 : int'(q.oct);
    for (int i = 0; i < n; i++) begin
      acc += lattice_noise(ux, uy, uz) >>> i;
      ux = ux << 1; uy = uy << 1; uz = uz << 1;
    end
    if (q.unit) acc = (acc >>> 1) + 32768;
    if (acc > 262143) acc = 262143;
    if (acc < -262144) acc = -262144;
    return acc[18:0];
  endfunction

  function automatic word_t mk_load(int idx, int val, int gap);
    word_t w;
    w.kind = KIND_LOAD; w.idx = 8'(idx); w.val = 8'(val);
    w.x = $urandom; w.y = $urandom; w.z = $urandom;
    w.oct = 4'($urandom); w.unit = 1'($urandom); w.gap = gap; w.drain = 1'b0;
    return w;
  endfunction

  function automatic word_t mk_query(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     int oct, int unit, int gap);
    word_t w;
    w.kind = KIND_QUERY; w.idx = 8'($urandom); w.val = 8'($urandom);
    w.x = x; w.y = y; w.z = z; w.oct = 4'(oct); w.unit = 1'(unit); w.gap = gap;
    w.drain = 1'b0;
    return w;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000f_ffff);
      2: return -$urandom_range(0, 32'h000f_ffff);
      default: return '0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        nv = 1'b0;
        if (cur.kind == KIND_LOAD) begin
          perm_mdl[cur.idx] = cur.val;
        end else begin
          noise_q.push_back(octave_sum(cur));
        end
        src_wait = cur.gap;
      end
      if (!nv) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (pending_q.size() > 0 && (!pending_q[0].drain || noise_q.size() == 0)) begin
          cur = pending_q.pop_front();
          nv = 1'b1;
          kind <= cur.kind;
          table_index <= cur.idx;
          table_value <= cur.val;
          coord_x <= cur.x;
          coord_y <= cur.y;
          coord_z <= cur.z;
          octave_count <= cur.oct;
          unit_range <= cur.unit;
        end
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [18:0] exp_v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (noise_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %0d", noise_value);
        end else begin
          exp_v = noise_q.pop_front();
          if (exp_v !== noise_value) begin
            n_err++;
            if (n_err <= 10)
              $display("noise_value mismatch: exp %0d got %0d", exp_v, noise_value);
          end
        end
        snk_wait = (n_results > 400 && n_results < 500) ? 0 : $urandom_range(0, 9);
        if (n_results == 200) hold_cnt = 2000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    word_t w;
    int sh[256];
    int tmp, j;
    for (int i = 0; i < 256; i++) sh[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = sh[i]; sh[i] = sh[j]; sh[j] = tmp;
    end
    for (int i = 0; i < 256; i++) pending_q.push_back(mk_load(i, sh[i], $urandom_range(0, 2)));
    // directed queries
    pending_q.push_back(mk_query(0, 0, 0, 1, 0, 3));
    pending_q.push_back(mk_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8, 0, 0));
    pending_q.push_back(mk_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8, 1, 5));
    pending_q.push_back(mk_query(32'h0000_ffff, 32'h0001_ffff, 32'hffff_ffff, 3, 0, 0));
    pending_q.push_back(mk_query(32'h0003_0000, 0, 0, 2, 0, 9));
    pending_q.push_back(mk_query(32'h0002_8000, 32'h0005_4000, 0, 4, 1, 0));
    pending_q.push_back(mk_query($urandom, $urandom, $urandom, 0, 0, 1));
    pending_q.push_back(mk_query($urandom, $urandom, $urandom, 0, 1, 0));
    pending_q.push_back(mk_query($urandom, $urandom, $urandom, 9, 0, 0));
    pending_q.push_back(mk_query($urandom, $urandom, $urandom, 15, 1, 2));
    pending_q.push_back(mk_query(32'hffff_0000, 32'h00ff_8000, 32'h0100_0000, 5, 0, 0));
    pending_q.push_back(mk_load(0, 8'hff, 0));
    pending_q.push_back(mk_load(8'hff, 8'h00, 0));
    pending_q.push_back(mk_query(32'h00ff_c000, 32'h00ff_c000, 32'h00ff_c000, 6, 0, 4));
    pending_q.push_back(mk_query(32'h0000_4000, 32'h0000_c000, 32'h0000_2000, 7, 1, 0));
    // random part
    for (int i = 0; i < 880; i++) begin
      int g, oc;
      g = (i > 500 && i < 580) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 15) begin
        w = mk_load($urandom, $urandom, g);
      end else begin
        oc = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
        w = mk_query(rnd_coord(), rnd_coord(), rnd_coord(), oc, $urandom_range(0, 1), g);
      end
      if (i == 700) w.drain = 1'b1;
      pending_q.push_back(w);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (noise_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
